// File: design/caret_semicolon_frame_parser_core_assert.svh
// assertion macros for the caret/semicolon frame parser
`ifndef CARET_SEMICOLON_FRAME_PARSER_CORE_ASSERT_SVH
`define CARET_SEMICOLON_FRAME_PARSER_CORE_ASSERT_SVH

// same-cycle implication
`define CSFP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("frame parser check failed");

// next-cycle implication
`define CSFP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("frame parser check failed");

`endif

// File: design/csfp_pkg.sv
// package for the caret/semicolon frame parser: codes, types, character classes
package csfp_pkg;

	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CASE_OFFSET = 8'h20;
	localparam int CMD_LEN_MAX = 3;
	localparam int FRAME_SLACK = 8;

	typedef enum logic {
		PH_COLLECT,
		PH_EMIT
	} phase_t;

	typedef struct packed {
		logic [6:0] first;
		logic [6:0] second;
		logic [6:0] third;
	} cmd_t;

	typedef struct packed {
		logic ok;
		logic present;
	} close_t;

	function automatic logic is_upper(input logic [7:0] c);
		return c inside {[8'h41:8'h5A]};
	endfunction

	function automatic logic is_lower(input logic [7:0] c);
		return c inside {[8'h61:8'h7A]};
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		logic hit;
		hit = is_upper(c) || is_lower(c);
		if (c inside {8'hAA, 8'hB5, 8'hBA})
			hit = 1'b1;
		if ((c inside {[8'hC0:8'hFF]}) && !(c inside {8'hD7, 8'hF7}))
			hit = 1'b1;
		return hit;
	endfunction

endpackage

// File: design/caret_semicolon_frame_parser_core.sv
// Caret/semicolon command frame parser: one received byte per input beat, frames of the form
// '^' command ';' with a 2 or 3 letter command and up to MAX_ARG argument bytes held in a
// chain of byte cells. While collecting, one byte is taken every cycle. After the ';' of a
// valid frame the input is held off while the results drain from the head of the cell chain,
// one per cycle when the output is ready, so a frame gives max(1, argument length) results
// on the output; the chain shifts one cell per result. No clearing pass after reset is needed.
module caret_semicolon_frame_parser_core #(
	parameter int MAX_ARG = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [6:0] cmd_first, [13:7] cmd_second, [20:14] cmd_third,
	                               // [28:21] arg_byte, [31:29] zero
	output logic        m_tuser,   // [0] arg_present
	output logic        m_tlast
);

	`include "caret_semicolon_frame_parser_core_assert.svh"

	localparam int IDX_W = (MAX_ARG > 1) ? $clog2(MAX_ARG) : 1;
	localparam int CNT_W = $clog2(MAX_ARG + 2);

	csfp_pkg::phase_t phase_q;
	csfp_pkg::phase_t phase_d;
	csfp_pkg::cmd_t   cmd;
	csfp_pkg::close_t close;

	logic             beat_in;
	logic             beat_out;
	logic             wr_en;
	logic [IDX_W-1:0] wr_idx;
	logic [CNT_W-1:0] arg_count;
	logic [CNT_W-1:0] remain_q;
	logic             present_q;
	logic [7:0]       chain [MAX_ARG];
	logic [7:0]       arg_byte;

	assign beat_in = s_tvalid && s_tready;
	assign beat_out = m_tvalid && m_tready;

	csfp_frame_ctrl #(
		.MAX_ARG(MAX_ARG),
		.IDX_W(IDX_W),
		.CNT_W(CNT_W)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.beat(beat_in),
		.rx_byte(s_tdata),
		.wr_en(wr_en),
		.wr_idx(wr_idx),
		.arg_count(arg_count),
		.cmd(cmd),
		.close(close)
	);

	for (genvar i = 0; i < MAX_ARG; i++) begin : g_cell
		logic [7:0] next_data;
		if (i == MAX_ARG - 1) begin : g_tail
			assign next_data = 8'h00;
		end else begin : g_link
			assign next_data = chain[i+1];
		end
		csfp_arg_cell #(
			.IDX_W(IDX_W),
			.INDEX(i)
		) u_cell (
			.clk(clk),
			.load(wr_en),
			.wr_idx(wr_idx),
			.din(s_tdata),
			.shift(beat_out),
			.next_data(next_data),
			.data(chain[i])
		);
	end

	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			csfp_pkg::PH_COLLECT: begin
				if (close.ok)
					phase_d = csfp_pkg::PH_EMIT;
			end
			csfp_pkg::PH_EMIT: begin
				if (beat_out && (remain_q == CNT_W'(1)))
					phase_d = csfp_pkg::PH_COLLECT;
			end
			default: phase_d = csfp_pkg::PH_COLLECT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= csfp_pkg::PH_COLLECT;
			remain_q <= '0;
			present_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (close.ok) begin
				remain_q <= close.present ? arg_count : CNT_W'(1);
				present_q <= close.present;
			end else if (beat_out) begin
				remain_q <= remain_q - CNT_W'(1);
			end
		end
	end

	always_comb begin
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		case (phase_q)
			csfp_pkg::PH_COLLECT: s_tready = 1'b1;
			csfp_pkg::PH_EMIT:    m_tvalid = 1'b1;
			default: begin
				s_tready = 1'b0;
				m_tvalid = 1'b0;
			end
		endcase
	end

	assign arg_byte = present_q ? chain[0] : 8'h00;
	assign m_tdata = {3'b000, arg_byte, cmd.third, cmd.second, cmd.first};
	assign m_tuser = present_q;
	assign m_tlast = (remain_q == CNT_W'(1));

	`CSFP_ASSERT_NOW(a_no_input_while_emit, phase_q == csfp_pkg::PH_EMIT, !s_tready)
	`CSFP_ASSERT_NEXT(a_close_starts_emit, close.ok, m_tvalid)
	`CSFP_ASSERT_NEXT(a_last_ends_emit, beat_out && m_tlast, s_tready && !m_tvalid)
	`CSFP_ASSERT_NOW(a_empty_arg_single, m_tvalid && !m_tuser, m_tlast)

endmodule

// File: design/csfp_arg_cell.sv
// one argument byte cell of the buffer chain
module csfp_arg_cell #(
	parameter int IDX_W = 5,
	parameter int INDEX = 0
) (
	input  logic             clk,
	input  logic             load,
	input  logic [IDX_W-1:0] wr_idx,
	input  logic [7:0]       din,
	input  logic             shift,
	input  logic [7:0]       next_data,
	output logic [7:0]       data
);

	logic [7:0] data_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= next_data;
		end else if (load && (wr_idx == IDX_W'(INDEX))) begin
			data_q <= din;
		end
	end

	assign data = data_q;

endmodule

// File: design/csfp_frame_ctrl.sv
// frame tracking: caret hunt, command letter run, argument count, overlong abandon
module csfp_frame_ctrl #(
	parameter int MAX_ARG = 32,
	parameter int IDX_W = 5,
	parameter int CNT_W = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                beat,
	input  logic [7:0]          rx_byte,
	output logic                wr_en,
	output logic [IDX_W-1:0]    wr_idx,
	output logic [CNT_W-1:0]    arg_count,
	output csfp_pkg::cmd_t      cmd,
	output csfp_pkg::close_t    close
);

	localparam int FC_MAX = MAX_ARG + csfp_pkg::FRAME_SLACK - 1;
	localparam int FC_W = $clog2(FC_MAX + 1);

	logic             in_frame_q;
	logic             in_letters_q;
	logic [FC_W-1:0]  frame_count_q;
	logic [2:0]       tok_len_q;
	logic             tok_bad_q;
	logic [CNT_W-1:0] arg_count_q;
	logic [6:0]       tok_q [csfp_pkg::CMD_LEN_MAX];

	logic       is_caret;
	logic       is_semi;
	logic       body;
	logic       letter;
	logic [7:0] up;

	assign is_caret = (rx_byte == csfp_pkg::CH_CARET);
	assign is_semi = (rx_byte == csfp_pkg::CH_SEMI);
	assign body = beat && in_frame_q && !is_caret && !is_semi;
	assign letter = in_letters_q && csfp_pkg::is_letter(rx_byte);
	assign up = csfp_pkg::is_lower(rx_byte) ? (rx_byte - csfp_pkg::CASE_OFFSET) : rx_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			in_letters_q <= 1'b0;
			frame_count_q <= '0;
			tok_len_q <= '0;
			tok_bad_q <= 1'b0;
			arg_count_q <= '0;
		end else if (beat) begin
			if (is_caret) begin
				in_frame_q <= 1'b1;
				in_letters_q <= 1'b1;
				frame_count_q <= '0;
				tok_len_q <= '0;
				tok_bad_q <= 1'b0;
				arg_count_q <= '0;
			end else if (in_frame_q) begin
				if (is_semi) begin
					in_frame_q <= 1'b0;
					in_letters_q <= 1'b0;
				end else begin
					if (letter) begin
						if ((tok_len_q < 3'(csfp_pkg::CMD_LEN_MAX)) && !csfp_pkg::is_upper(up))
							tok_bad_q <= 1'b1;
						if (tok_len_q >= 3'(csfp_pkg::CMD_LEN_MAX))
							tok_bad_q <= 1'b1;
						if (tok_len_q <= 3'(csfp_pkg::CMD_LEN_MAX))
							tok_len_q <= tok_len_q + 3'd1;
					end else begin
						in_letters_q <= 1'b0;
						if (arg_count_q <= CNT_W'(MAX_ARG))
							arg_count_q <= arg_count_q + CNT_W'(1);
					end
					if (frame_count_q == FC_W'(FC_MAX)) begin
						in_frame_q <= 1'b0;
						in_letters_q <= 1'b0;
						frame_count_q <= '0;
					end else begin
						frame_count_q <= frame_count_q + FC_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (body && letter && (tok_len_q < 3'(csfp_pkg::CMD_LEN_MAX)))
			tok_q[tok_len_q[1:0]] <= up[6:0];
	end

	assign wr_en = body && !letter && (arg_count_q < CNT_W'(MAX_ARG));
	assign wr_idx = arg_count_q[IDX_W-1:0];
	assign arg_count = arg_count_q;

	assign cmd.first = tok_q[0];
	assign cmd.second = tok_q[1];
	assign cmd.third = (tok_len_q == 3'(csfp_pkg::CMD_LEN_MAX)) ? tok_q[2] : 7'd0;

	assign close.ok = beat && in_frame_q && is_semi && !tok_bad_q
		&& ((tok_len_q == 3'd2) || (tok_len_q == 3'd3))
		&& (arg_count_q <= CNT_W'(MAX_ARG));
	assign close.present = (arg_count_q != '0);

endmodule

// File: tb/frame_parser_checker.sv
// beat monitor, frame parsing predictor and result comparison for the frame parser
module frame_parser_checker #(
	parameter int MAX_ARG = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	input  logic        m_tuser,
	input  logic        m_tlast,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [6:0] first;
		logic [6:0] second;
		logic [6:0] third;
		logic [7:0] arg;
		logic       present;
		logic       last;
	} cmd_beat_t;

	cmd_beat_t   cmd_beat_q[$];
	cmd_beat_t   want;
	logic        in_frame;
	logic        in_cmd;
	logic        cmd_bad;
	int unsigned body_len;
	int unsigned cmd_len;
	int unsigned arg_len;
	logic [7:0]  cmd_chars [3];
	logic [7:0]  arg_buf [MAX_ARG];

	function automatic bit latin_letter(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
			c == 8'hAA || c == 8'hB5 || c == 8'hBA ||
			(c >= 8'hC0 && c != 8'hD7 && c != 8'hF7);
	endfunction

	task automatic parse_byte(input logic [7:0] b);
		int unsigned n;
		logic [7:0] u;
		cmd_beat_t r;
		if (b == csfp_pkg::CH_CARET) begin
			in_frame = 1'b1;
			in_cmd = 1'b1;
			body_len = 0;
			cmd_len = 0;
			cmd_bad = 1'b0;
			arg_len = 0;
		end else if (in_frame) begin
			if (b == csfp_pkg::CH_SEMI) begin
				in_frame = 1'b0;
				in_cmd = 1'b0;
				if (!cmd_bad && cmd_len >= 2 && cmd_len <= 3 && arg_len <= MAX_ARG) begin
					n = (arg_len == 0) ? 1 : arg_len;
					for (int unsigned i = 0; i < n; i++) begin
						r.first = cmd_chars[0][6:0];
						r.second = cmd_chars[1][6:0];
						r.third = (cmd_len == 3) ? cmd_chars[2][6:0] : 7'd0;
						r.arg = (arg_len == 0) ? 8'd0 : arg_buf[i];
						r.present = (arg_len != 0);
						r.last = (i + 1 == n);
						cmd_beat_q.push_back(r);
					end
				end
			end else begin
				if (in_cmd && latin_letter(b)) begin
					if (cmd_len < 3) begin
						u = (b >= 8'h61 && b <= 8'h7A) ? b - csfp_pkg::CASE_OFFSET : b;
						cmd_chars[cmd_len] = u;
						if (!(u >= 8'h41 && u <= 8'h5A))
							cmd_bad = 1'b1;
					end
					if (cmd_len < 4)
						cmd_len++;
					if (cmd_len > 3)
						cmd_bad = 1'b1;
				end else begin
					in_cmd = 1'b0;
					if (arg_len < MAX_ARG)
						arg_buf[arg_len] = b;
					if (arg_len <= MAX_ARG)
						arg_len++;
				end
				body_len++;
				// overlong frame, back to hunting for a caret
				if (body_len > MAX_ARG + 7) begin
					in_frame = 1'b0;
					in_cmd = 1'b0;
					body_len = 0;
				end
			end
		end
	endtask

	task automatic check_field(input string name, input logic [7:0] exp, input logic [7:0] act);
		if (exp !== act) begin
			$error("%s: expected %0h, got %0h", name, exp, act);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame = 1'b0;
			in_cmd = 1'b0;
			cmd_bad = 1'b0;
			body_len = 0;
			cmd_len = 0;
			arg_len = 0;
			cmd_beat_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (s_tvalid && s_tready)
				parse_byte(s_tdata);
			if (m_tvalid && m_tready) begin
				if (cmd_beat_q.size() == 0) begin
					$error("result beat with none expected: tdata %0h", m_tdata);
					fail_count++;
				end else begin
					want = cmd_beat_q.pop_front();
					check_field("cmd_first", 8'(want.first), 8'(m_tdata[6:0]));
					check_field("cmd_second", 8'(want.second), 8'(m_tdata[13:7]));
					check_field("cmd_third", 8'(want.third), 8'(m_tdata[20:14]));
					check_field("arg_byte", want.arg, m_tdata[28:21]);
					check_field("arg_present", 8'(want.present), 8'(m_tuser));
					check_field("last", 8'(want.last), 8'(m_tlast));
				end
			end
			pending = cmd_beat_q.size();
		end
	end

endmodule

// File: tb/tb.sv
// testbench top for the frame parser: clock, reset, byte stimulus and verdict
module tb;

	localparam int MAX_ARG = 32;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [7:0]  s_tdata = 8'd0;
	logic        m_tready = 1'b0;
	logic        s_tready;
	logic        m_tvalid;
	logic [31:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	int          fail_count;
	int          pending;
	int          send_idle = 0;
	int          recv_idle = 0;
	int          bytes_sent = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	caret_semicolon_frame_parser_core #(
		.MAX_ARG(MAX_ARG)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	frame_parser_checker #(
		.MAX_ARG(MAX_ARG)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.fail_count(fail_count),
		.pending(pending)
	);

	always @(negedge clk) begin
		m_tready <= (recv_idle == 0) || ($urandom_range(99) >= recv_idle);
	end

	task automatic put_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put_byte(s[i]);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	task automatic send_command_frame();
		int r;
		int cmd_n;
		int arg_n;
		logic [7:0] b;
		if ($urandom_range(9) == 0)
			wait_drained();
		// line noise while hunting
		if ($urandom_range(9) < 3)
			repeat ($urandom_range(3, 1)) put_byte(8'($urandom_range(255)));
		put_byte(csfp_pkg::CH_CARET);
		r = $urandom_range(99);
		cmd_n = (r < 4) ? 0 : (r < 10) ? 1 : (r < 50) ? 2 : (r < 92) ? 3 : $urandom_range(5, 4);
		for (int i = 0; i < cmd_n; i++) begin
			r = $urandom_range(19);
			if (r == 0)
				b = 8'($urandom_range(8'hFF, 8'hC0));
			else if (r == 1)
				b = 8'hB5;
			else if (r < 11)
				b = 8'($urandom_range(8'h5A, 8'h41));
			else
				b = 8'($urandom_range(8'h7A, 8'h61));
			put_byte(b);
		end
		r = $urandom_range(99);
		arg_n = (r < 70) ? $urandom_range(6) : (r < 80) ? $urandom_range(20, 7) :
			(r < 93) ? $urandom_range(MAX_ARG + 2, MAX_ARG - 2) :
			$urandom_range(MAX_ARG + 10, MAX_ARG + 6);
		for (int i = 0; i < arg_n; i++) begin
			if (i == 0) begin
				b = 8'($urandom_range(8'h40, 8'h21));
				if (b == csfp_pkg::CH_SEMI)
					b = 8'h3D;
			end else begin
				b = 8'($urandom_range(255));
				if (b == csfp_pkg::CH_CARET || b == csfp_pkg::CH_SEMI)
					b = b ^ 8'h01;
			end
			put_byte(b);
		end
		r = $urandom_range(99);
		if (r < 88)
			put_byte(csfp_pkg::CH_SEMI);
		else if (r >= 94)
			put_byte(8'($urandom_range(255)));
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		send_idle = 37;
		recv_idle = 55;
		put_text(";A");
		put_text("^AB;");
		put_text("^abc");
		put_byte(8'h00);
		put_byte(8'hFF);
		put_text(";");
		put_text("^X^KY=1;");
		put_text("^A1;");
		wait_drained();
		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 37 : (ph == 1) ? 55 : 0;
			recv_idle = (ph == 0) ? 55 : (ph == 1) ? 37 : 0;
			while (bytes_sent < 25 + (ph + 1) * 55)
				send_command_frame();
			wait_drained();
		end
		repeat (20) @(negedge clk);
		if (fail_count == 0)
			$display("** caret_semicolon_frame_parser_core: PASSED **");
		else
			$display("** caret_semicolon_frame_parser_core: FAILED **");
		$finish;
	end

	initial begin
		#400000;
		$display("** caret_semicolon_frame_parser_core: FAILED **");
		$finish;
	end

endmodule
